// File: hdl/stok_pkg.sv
// shared types, codes and character classes for the source tokenizer
// no dependencies; source_tokenizer and stok_checker import this package
`default_nettype none

package stok_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_MINUS
  } mode_t;

  localparam logic [2:0] KIND_IDENT    = 3'd0;
  localparam logic [2:0] KIND_NUMBER   = 3'd1;
  localparam logic [2:0] KIND_STRING   = 3'd2;
  localparam logic [2:0] KIND_ARROW    = 3'd3;
  localparam logic [2:0] KIND_FUNCTION = 3'd4;
  localparam logic [2:0] KIND_RETURN   = 3'd5;
  localparam logic [2:0] KIND_PUNCT    = 3'd6;

  localparam logic REC_CONTENT  = 1'b0;
  localparam logic REC_COMPLETE = 1'b1;

  localparam logic [7:0] CH_MINUS     = 8'h2d;
  localparam logic [7:0] CH_GT        = 8'h3e;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LOWER_N   = 8'h6e;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NUL       = 8'h00;

  localparam logic [3:0] LEN_FUNCTION = 4'd8;
  localparam logic [3:0] LEN_RETURN   = 4'd6;
  localparam logic [3:0] LEN_MAX      = 4'd15;

  // result queue between the scanner and the output channel
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       record_type;
    logic [2:0] token_kind;
    logic [7:0] char_value;
    logic       unterminated;
    logic       last_of_item;
  } rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h7b) || (c == 8'h7d) ||
           (c == 8'h3b);
  endfunction

  // letters of "function", indexed by position
  function automatic logic [7:0] kw_function_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h66;
      3'd1:    ch = 8'h75;
      3'd2:    ch = 8'h6e;
      3'd3:    ch = 8'h63;
      3'd4:    ch = 8'h74;
      3'd5:    ch = 8'h69;
      3'd6:    ch = 8'h6f;
      default: ch = 8'h6e;
    endcase
    return ch;
  endfunction

  // letters of "return", indexed by position; positions past the end never match
  function automatic logic [7:0] kw_return_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h72;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h75;
      3'd4:    ch = 8'h72;
      3'd5:    ch = 8'h6e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hdl/stok_text_if.sv
// valid/ready channel carrying source bytes into the tokenizer
// standalone interface, no package dependency
`default_nettype none

interface stok_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: hdl/stok_token_if.sv
// valid/ready channel carrying token records out of the tokenizer
// standalone interface, no package dependency
`default_nettype none

interface stok_token_if;
  logic       valid;
  logic       ready;
  logic       record_type;
  logic [2:0] token_kind;
  logic [7:0] char_value;
  logic       unterminated;
  logic       last_of_item;

  modport source (output valid, output record_type, output token_kind,
                  output char_value, output unterminated, output last_of_item,
                  input ready);
  modport sink   (input valid, input record_type, input token_kind,
                  input char_value, input unterminated, input last_of_item,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/source_tokenizer.sv
// path: an input transfer lands in the input register, its records go into the result queue, which drives the output
// throughput: one input item per cycle while each byte gives at most one record and
//   the output is taken; a byte that closes a token and opens another gives two
//   records, and the one-record-per-cycle output port then sets the pace
// reset: synchronous active-high rst empties the input register and the result
//   queue and returns the scanner to idle with keyword matches armed
// depends on stok_pkg, stok_text_if and stok_token_if
`default_nettype none

module source_tokenizer (
  input  wire logic   clk,
  input  wire logic   rst,
  stok_text_if.sink   text,
  stok_token_if.source tokens
);
  import stok_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_end;

  // scanner state
  mode_t      mode, mode_next;
  logic [3:0] ident_len, ident_len_next;
  logic       match_fn, match_fn_next;
  logic       match_ret, match_ret_next;

  // result queue
  rec_t              queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic       advance;
  logic       pop;
  logic [1:0] n_rec;
  rec_t       rec0, rec1;

  // fresh-byte scan: what a byte does when no token is open
  mode_t      fr_mode;
  logic       fr_emit;
  rec_t       fr_rec;
  logic       fr_ident;

  // keyword tracking while extending an identifier
  logic       feed_fn, feed_ret;
  logic [3:0] feed_len;
  logic [2:0] ident_kind;

  // the scanner works on the registered item once the queue has room for two records
  assign advance     = in_valid && (count <= QCNT_W'(QDEPTH - 2));
  assign text.ready  = !in_valid || advance;
  assign pop         = tokens.valid && tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_char <= text.in_byte;
      in_end  <= text.end_of_text;
    end
  end

  // classify a byte seen with no open token
  always_comb begin
    fr_mode  = MODE_IDLE;
    fr_emit  = 1'b0;
    fr_ident = 1'b0;
    fr_rec   = '{REC_CONTENT, KIND_IDENT, in_char, 1'b0, 1'b0};
    if (is_space(in_char)) begin
      fr_mode = MODE_IDLE;
    end else if (in_char == CH_MINUS) begin
      fr_mode = MODE_MINUS;
    end else if (is_punct(in_char)) begin
      fr_emit = 1'b1;
      fr_rec  = '{REC_COMPLETE, KIND_PUNCT, in_char, 1'b0, 1'b0};
    end else if (is_digit(in_char)) begin
      fr_mode = MODE_NUMBER;
      fr_emit = 1'b1;
      fr_rec  = '{REC_CONTENT, KIND_NUMBER, in_char, 1'b0, 1'b0};
    end else if (in_char == CH_QUOTE) begin
      fr_mode = MODE_STRING;
    end else if (is_alpha(in_char) || in_char == CH_UNDERSCORE) begin
      fr_mode  = MODE_IDENT;
      fr_emit  = 1'b1;
      fr_ident = 1'b1;
      fr_rec   = '{REC_CONTENT, KIND_IDENT, in_char, 1'b0, 1'b0};
    end
  end

  // one more identifier byte: drop keyword candidates that no longer fit
  always_comb begin
    feed_fn  = match_fn && (ident_len < LEN_FUNCTION) &&
               (in_char == kw_function_char(ident_len[2:0]));
    feed_ret = match_ret && (ident_len < LEN_RETURN) &&
               (in_char == kw_return_char(ident_len[2:0]));
    feed_len = (ident_len < LEN_MAX) ? ident_len + 4'd1 : ident_len;
    if (ident_len == LEN_FUNCTION && match_fn) begin
      ident_kind = KIND_FUNCTION;
    end else if (ident_len == LEN_RETURN && match_ret) begin
      ident_kind = KIND_RETURN;
    end else begin
      ident_kind = KIND_IDENT;
    end
  end

  // main scanner: up to two records per item
  always_comb begin
    logic take_fresh;
    take_fresh     = 1'b0;
    mode_next      = mode;
    ident_len_next = ident_len;
    match_fn_next  = match_fn;
    match_ret_next = match_ret;
    n_rec          = 2'd0;
    rec0           = '{REC_CONTENT, KIND_IDENT, in_char, 1'b0, 1'b0};
    rec1           = fr_rec;

    if (in_end) begin
      // flush whatever token is open and rearm everything
      unique case (mode)
        MODE_NUMBER: begin
          n_rec = 2'd1;
          rec0  = '{REC_COMPLETE, KIND_NUMBER, CH_NUL, 1'b0, 1'b0};
        end
        MODE_IDENT: begin
          n_rec = 2'd1;
          rec0  = '{REC_COMPLETE, ident_kind, CH_NUL, 1'b0, 1'b0};
        end
        MODE_STRING, MODE_ESCAPE: begin
          n_rec = 2'd1;
          rec0  = '{REC_COMPLETE, KIND_STRING, CH_NUL, 1'b1, 1'b0};
        end
        MODE_MINUS: begin
          n_rec = 2'd1;
          rec0  = '{REC_COMPLETE, KIND_PUNCT, CH_MINUS, 1'b0, 1'b0};
        end
        default: begin
          n_rec = 2'd0;
        end
      endcase
      mode_next      = MODE_IDLE;
      ident_len_next = 4'd0;
      match_fn_next  = 1'b1;
      match_ret_next = 1'b1;
    end else begin
      unique case (mode)
        MODE_NUMBER: begin
          n_rec = 2'd1;
          if (is_digit(in_char)) begin
            rec0 = '{REC_CONTENT, KIND_NUMBER, in_char, 1'b0, 1'b0};
          end else begin
            rec0       = '{REC_COMPLETE, KIND_NUMBER, CH_NUL, 1'b0, 1'b0};
            take_fresh = 1'b1;
          end
        end
        MODE_IDENT: begin
          n_rec = 2'd1;
          if (is_alpha(in_char) || is_digit(in_char) || in_char == CH_UNDERSCORE) begin
            rec0           = '{REC_CONTENT, KIND_IDENT, in_char, 1'b0, 1'b0};
            ident_len_next = feed_len;
            match_fn_next  = feed_fn;
            match_ret_next = feed_ret;
          end else begin
            rec0       = '{REC_COMPLETE, ident_kind, CH_NUL, 1'b0, 1'b0};
            take_fresh = 1'b1;
          end
        end
        MODE_STRING: begin
          if (in_char == CH_QUOTE) begin
            n_rec     = 2'd1;
            rec0      = '{REC_COMPLETE, KIND_STRING, CH_NUL, 1'b0, 1'b0};
            mode_next = MODE_IDLE;
          end else if (in_char == CH_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end else begin
            n_rec = 2'd1;
            rec0  = '{REC_CONTENT, KIND_STRING, in_char, 1'b0, 1'b0};
          end
        end
        MODE_ESCAPE: begin
          // only n and t survive an escape
          if (in_char == CH_LOWER_N) begin
            n_rec = 2'd1;
            rec0  = '{REC_CONTENT, KIND_STRING, CH_NEWLINE, 1'b0, 1'b0};
          end else if (in_char == CH_LOWER_T) begin
            n_rec = 2'd1;
            rec0  = '{REC_CONTENT, KIND_STRING, CH_TAB, 1'b0, 1'b0};
          end
          mode_next = MODE_STRING;
        end
        MODE_MINUS: begin
          n_rec = 2'd1;
          if (in_char == CH_GT) begin
            rec0      = '{REC_COMPLETE, KIND_ARROW, CH_NUL, 1'b0, 1'b0};
            mode_next = MODE_IDLE;
          end else begin
            rec0       = '{REC_COMPLETE, KIND_PUNCT, CH_MINUS, 1'b0, 1'b0};
            take_fresh = 1'b1;
          end
        end
        default: begin
          // idle: the byte is scanned fresh and its record, if any, goes first
          mode_next = fr_mode;
          n_rec     = {1'b0, fr_emit};
          rec0      = fr_rec;
          if (fr_ident) begin
            ident_len_next = 4'd1;
            match_fn_next  = (in_char == kw_function_char(3'd0));
            match_ret_next = (in_char == kw_return_char(3'd0));
          end
        end
      endcase

      // the byte that closed a token is rescanned as a fresh byte
      if (take_fresh) begin
        mode_next = fr_mode;
        n_rec     = fr_emit ? 2'd2 : 2'd1;
        if (fr_ident) begin
          ident_len_next = 4'd1;
          match_fn_next  = (in_char == kw_function_char(3'd0));
          match_ret_next = (in_char == kw_return_char(3'd0));
        end
      end
    end

    rec0.last_of_item = (n_rec == 2'd1);
    rec1.last_of_item = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      ident_len <= 4'd0;
      match_fn  <= 1'b1;
      match_ret <= 1'b1;
    end else if (advance) begin
      mode      <= mode_next;
      ident_len <= ident_len_next;
      match_fn  <= match_fn_next;
      match_ret <= match_ret_next;
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + QPTR_W'(n_rec);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(advance ? n_rec : 2'd0) - QCNT_W'(pop);
    end
  end

  // queue storage holds payload only
  always_ff @(posedge clk) begin
    if (advance && n_rec != 2'd0) begin
      queue[wr_ptr] <= rec0;
    end
    if (advance && n_rec == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= rec1;
    end
  end

  assign tokens.valid        = (count != '0);
  assign tokens.record_type  = queue[rd_ptr].record_type;
  assign tokens.token_kind   = queue[rd_ptr].token_kind;
  assign tokens.char_value   = queue[rd_ptr].char_value;
  assign tokens.unterminated = queue[rd_ptr].unterminated;
  assign tokens.last_of_item = queue[rd_ptr].last_of_item;

endmodule

`default_nettype wire

// File: hdl/stok_checker.sv
// port-level checks on the token output of source_tokenizer, with its bind
// depends on stok_pkg and on the ports of source_tokenizer
`default_nettype none

module stok_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic       record_type,
  input wire logic [2:0] token_kind,
  input wire logic [7:0] char_value,
  input wire logic       unterminated
);
  import stok_pkg::*;

  // a record offered is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("token record withdrawn before transfer");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("token output valid after reset");

  // only a string completion can be flagged unterminated
  a_unterm: assert property (@(posedge clk) disable iff (rst)
    valid && unterminated |-> record_type == REC_COMPLETE && token_kind == KIND_STRING)
    else $error("unterminated flag on a record that is not a string completion");

  // content records belong to identifiers, numbers or strings
  a_content_kind: assert property (@(posedge clk) disable iff (rst)
    valid && record_type == REC_CONTENT |->
      token_kind == KIND_IDENT || token_kind == KIND_NUMBER || token_kind == KIND_STRING)
    else $error("content record with a completion-only kind");

  // completions other than punctuation carry no character
  a_complete_char: assert property (@(posedge clk) disable iff (rst)
    valid && record_type == REC_COMPLETE && token_kind != KIND_PUNCT |->
      char_value == CH_NUL)
    else $error("completion record carries a character");

endmodule

bind source_tokenizer stok_checker u_stok_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (tokens.valid),
  .ready        (tokens.ready),
  .record_type  (tokens.record_type),
  .token_kind   (tokens.token_kind),
  .char_value   (tokens.char_value),
  .unterminated (tokens.unterminated)
);

`default_nettype wire
